[rtl/lru_cache_tag_store_assert.svh]
// Assertion macros shared by the tag store RTL files.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef LRU_CACHE_TAG_STORE_ASSERT_SVH
`define LRU_CACHE_TAG_STORE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define LCTS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define LCTS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lcts_pkg.sv]
// Package for the LRU cache tag store: sizes, sequencer states and control structs.
// Depends on nothing; used by lcts_rank and lru_cache_tag_store.
`default_nettype none

package lcts_pkg;

	localparam int CACHE_SLOTS = 16;
	localparam int KEY_BITS    = 32;
	localparam int KEY_PORT_W  = 32;
	localparam int SLOT_PORT_W = 4;
	localparam int SLOT_W      = $clog2(CACHE_SLOTS);
	localparam int RANK_W      = SLOT_W;
	localparam int CNT_W       = $clog2(CACHE_SLOTS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} lcts_state_t;

	typedef enum logic [1:0] {
		RANK_HOLD,
		RANK_TOUCH,
		RANK_INSERT
	} rank_op_t;

	// Update request from the sequencer to the recency bank.
	typedef struct packed {
		rank_op_t            op;
		logic [SLOT_W-1:0]   slot;
		logic [SLOT_W-1:0]   evict_slot;
	} rank_cmd_t;

	// Status of the slot under scan plus the fill state of the store.
	typedef struct packed {
		logic valid;
		logic oldest;
		logic at_limit;
	} rank_look_t;

endpackage

`default_nettype wire

[rtl/lru_cache_tag_store.sv]
// Top level of the fully associative LRU cache tag store.
// Depends on lcts_pkg, lcts_rank and the assertion macros in lru_cache_tag_store_assert.svh.
`default_nettype none
`include "lru_cache_tag_store_assert.svh"

// Channel   Handshake            Word
// request   start, busy          key
// result    done (strobe)        hit, slot, evicted_valid, evicted_key
//
// A request is taken at a clock edge with start high and busy low. The sequencer then
// reads the tag memory one slot per cycle and runs each tag through a single key
// comparator, so busy stays high through the scan of all slots, a drain state for the
// last registered read to reach the comparator, and a commit state. The result word
// shows with done in the cycle after commit; busy is already low then, so the next
// start may come in that very cycle, but no new request is taken while one is in
// progress. Reset clears the sequencer, valid bits, ranks and count at once; the tag
// memory is not cleared and needs no clearing pass. The receiver cannot stall the
// result, so done lasts exactly one cycle.

module lru_cache_tag_store (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output      logic                           busy,
	input  wire logic [lcts_pkg::KEY_PORT_W-1:0]  key,
	output      logic                           done,
	output      logic                           hit,
	output      logic [lcts_pkg::SLOT_PORT_W-1:0] slot,
	output      logic                           evicted_valid,
	output      logic [lcts_pkg::KEY_PORT_W-1:0]  evicted_key
);
	import lcts_pkg::*;

	// Sequencer.
	lcts_state_t state_q, state_d;
	logic [SLOT_W-1:0] idx_q;
	logic accept;
	logic scan_en;
	logic commit;

	// Tag memory and the compare stage behind its registered read.
	logic [KEY_BITS-1:0] tag_mem [CACHE_SLOTS];
	logic [KEY_BITS-1:0] rd_tag_s1;
	logic                cmp_v_s1;
	logic [SLOT_W-1:0]   cmp_idx_s1;
	logic                key_match;

	// Per-request search results.
	logic [KEY_BITS-1:0] key_q;
	logic                found_q;
	logic [SLOT_W-1:0]   found_idx_q;
	logic                free_found_q;
	logic [SLOT_W-1:0]   free_idx_q;
	logic [SLOT_W-1:0]   old_idx_q;
	logic [KEY_BITS-1:0] old_key_q;

	// Result word.
	logic                   done_q;
	logic                   hit_q;
	logic [SLOT_W-1:0]      slot_q;
	logic                   ev_valid_q;
	logic [KEY_BITS-1:0]    ev_key_q;

	rank_cmd_t  rank_cmd;
	rank_look_t look;

	assign accept = start && !busy;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == SLOT_W'(CACHE_SLOTS - 1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy    = 1'b1;
		scan_en = 1'b0;
		commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_SCAN: begin
				scan_en = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_COMMIT: begin
				commit = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			cmp_v_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= scan_en;
			done_q   <= commit;
			if (accept) begin
				idx_q <= '0;
			end else if (scan_en) begin
				idx_q <= idx_q + SLOT_W'(1);
			end
		end
	end

	// Tag memory: one read per scan cycle, one write when a missed key is committed.
	always_ff @(posedge clk) begin
		if (scan_en) begin
			rd_tag_s1 <= tag_mem[idx_q];
		end
		if (commit && !found_q) begin
			tag_mem[free_idx_q] <= key_q;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_en) begin
			cmp_idx_s1 <= idx_q;
		end
	end

	// The one shared comparator: the tag read out this cycle against the request key.
	assign key_match = (rd_tag_s1 == key_q);

	// Collect the first hit, the lowest free slot and the least recent entry as the
	// slots stream past. Ranks and valid bits do not change during a scan.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q        <= KEY_BITS'(key);
			found_q      <= 1'b0;
			found_idx_q  <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			old_idx_q    <= '0;
			old_key_q    <= '0;
		end else if (cmp_v_s1) begin
			if (look.valid && !found_q && key_match) begin
				found_q     <= 1'b1;
				found_idx_q <= cmp_idx_s1;
			end
			if (!look.valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= cmp_idx_s1;
			end
			if (look.oldest) begin
				old_idx_q <= cmp_idx_s1;
				old_key_q <= rd_tag_s1;
			end
		end
	end

	// Recency update at commit: a hit moves the found entry to the front, a miss
	// inserts at the free slot and, when the store would be full, drops the oldest.
	always_comb begin
		rank_cmd.op         = RANK_HOLD;
		rank_cmd.slot       = found_q ? found_idx_q : free_idx_q;
		rank_cmd.evict_slot = old_idx_q;
		if (commit) begin
			rank_cmd.op = found_q ? RANK_TOUCH : RANK_INSERT;
		end
	end

	lcts_rank u_rank (
		.clk      (clk),
		.arst_n   (arst_n),
		.look_idx (cmp_idx_s1),
		.cmd      (rank_cmd),
		.look     (look)
	);

	// Result word, registered at commit.
	always_ff @(posedge clk) begin
		if (commit) begin
			hit_q      <= found_q;
			slot_q     <= found_q ? found_idx_q : free_idx_q;
			ev_valid_q <= !found_q && look.at_limit;
			ev_key_q   <= (!found_q && look.at_limit) ? old_key_q : '0;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign slot          = SLOT_PORT_W'(slot_q);
	assign evicted_valid = ev_valid_q;
	assign evicted_key   = KEY_PORT_W'(ev_key_q);

	`LCTS_ASSERT_SAME(a_done_when_idle, clk, arst_n, done_q, state_q == ST_IDLE, "result strobe outside idle")
	`LCTS_ASSERT_SAME(a_hit_no_evict, clk, arst_n, done_q && hit_q, !ev_valid_q && (ev_key_q == '0), "eviction reported on a hit")
	`LCTS_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, accept, busy && (idx_q == '0), "accepted request did not start a scan")
	`LCTS_ASSERT_SAME(a_commit_has_slot, clk, arst_n, commit, found_q || free_found_q, "commit without a hit or a free slot")

endmodule

`default_nettype wire

[rtl/lcts_rank.sv]
// Recency bank: valid bits, per-slot recency ranks and the resident count.
// Depends on lcts_pkg and on the assertion macros in lru_cache_tag_store_assert.svh.
`default_nettype none
`include "lru_cache_tag_store_assert.svh"

module lcts_rank (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [lcts_pkg::SLOT_W-1:0] look_idx,
	input  wire lcts_pkg::rank_cmd_t       cmd,
	output      lcts_pkg::rank_look_t      look
);
	import lcts_pkg::*;

	logic [CACHE_SLOTS-1:0] valid_q;
	logic [RANK_W-1:0]      rank_q [CACHE_SLOTS];
	logic [CNT_W-1:0]       count_q;
	logic                   at_limit;

	// Rank 0 is the most recent entry; the least recent one holds count minus one.
	assign at_limit      = (count_q == CNT_W'(CACHE_SLOTS - 1));
	assign look.valid    = valid_q[look_idx];
	assign look.oldest   = valid_q[look_idx] &&
		(CNT_W'(rank_q[look_idx]) == count_q - CNT_W'(1));
	assign look.at_limit = at_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int s = 0; s < CACHE_SLOTS; s++) begin
				rank_q[s] <= '0;
			end
		end else begin
			case (cmd.op)
				RANK_TOUCH: begin
					for (int s = 0; s < CACHE_SLOTS; s++) begin
						if (SLOT_W'(s) == cmd.slot) begin
							rank_q[s] <= '0;
						end else if (valid_q[s] && (rank_q[s] < rank_q[cmd.slot])) begin
							rank_q[s] <= rank_q[s] + RANK_W'(1);
						end
					end
				end
				RANK_INSERT: begin
					for (int s = 0; s < CACHE_SLOTS; s++) begin
						if (SLOT_W'(s) == cmd.slot) begin
							valid_q[s] <= 1'b1;
							rank_q[s]  <= '0;
						end else if (at_limit && (SLOT_W'(s) == cmd.evict_slot)) begin
							valid_q[s] <= 1'b0;
							rank_q[s]  <= '0;
						end else if (valid_q[s]) begin
							rank_q[s] <= rank_q[s] + RANK_W'(1);
						end
					end
					if (!at_limit) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	`LCTS_ASSERT_ALWAYS(a_count_matches_valid, clk, arst_n, $countones(valid_q) == 32'(count_q), "resident count disagrees with valid bits")
	`LCTS_ASSERT_ALWAYS(a_count_below_size, clk, arst_n, count_q < CNT_W'(CACHE_SLOTS), "resident count reached the slot count")
	`LCTS_ASSERT_NEXT(a_updated_slot_valid, clk, arst_n, cmd.op != RANK_HOLD, valid_q[$past(cmd.slot)], "touched or inserted slot is not valid")

endmodule

`default_nettype wire
